[sv/m68k_operand_ext_word_encoder_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 68000 operand encoder.
// Both macros expect signals named clk and arst_n in the scope where they
// are used. Checks are held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef M68K_OPERAND_EXT_WORD_ENCODER_TOP_ASSERT_SVH
`define M68K_OPERAND_EXT_WORD_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication check.
`define M68K_EA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define M68K_EA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/m68k_ea_pkg.sv]
// ----------------------------------------------------------------------------
// m68k_ea_pkg
// Types and constants shared by the 68000 operand encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package m68k_ea_pkg;

	// Addressing modes as presented at the input.
	typedef enum logic [3:0] {
		MODE_DN       = 4'd0,
		MODE_AN       = 4'd1,
		MODE_AN_IND   = 4'd2,
		MODE_AN_POST  = 4'd3,
		MODE_AN_PRE   = 4'd4,
		MODE_AN_DISP  = 4'd5,
		MODE_AN_IDX   = 4'd6,
		MODE_ABS_W    = 4'd7,
		MODE_ABS_L    = 4'd8,
		MODE_PC_DISP  = 4'd9,
		MODE_PC_IDX   = 4'd10,
		MODE_IMM      = 4'd11
	} addr_mode_t;

	// Error codes reported on the last result of an operand.
	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_D16      = 3'd1,
		ERR_D8       = 3'd2,
		ERR_PC_D16   = 3'd3,
		ERR_ABS_W    = 3'd4,
		ERR_IMM8     = 3'd5,
		ERR_IMM16    = 3'd6,
		ERR_BAD_MODE = 3'd7
	} err_code_t;

	// Operand size codes.
	localparam logic [1:0] SIZE_BYTE = 2'd1;
	localparam logic [1:0] SIZE_LONG = 2'd3;

	// Effective-address fields of the mode 7 forms.
	localparam logic [5:0] EA_ABS_W   = 6'h38;
	localparam logic [5:0] EA_ABS_L   = 6'h39;
	localparam logic [5:0] EA_PC_DISP = 6'h3A;
	localparam logic [5:0] EA_PC_IDX  = 6'h3B;
	localparam logic [5:0] EA_IMM     = 6'h3C;

	// One accepted operand.
	typedef struct packed {
		logic [3:0]  addr_mode;
		logic [2:0]  base_reg;
		logic [31:0] operand_value;
		logic [3:0]  index_reg_num;
		logic        index_is_long;
		logic [1:0]  operand_size;
		logic [31:0] location;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [5:0]  ea_field;
		logic        ea_valid;
		logic [15:0] ext_word;
		logic        word_valid;
		logic        last_result;
		err_code_t   error_code;
		logic [31:0] next_location;
	} result_t;

	// Status of the result stage, watched by the top level.
	typedef struct packed {
		logic out_valid;
		logic pend_valid;
	} emit_status_t;

endpackage

`default_nettype wire

[sv/m68k_ea_calc.sv]
// ----------------------------------------------------------------------------
// m68k_ea_calc
// Combinational encoder: forms the EA field, the extension words, the range
// checks and the advanced locations for one registered operand.
// ----------------------------------------------------------------------------
`default_nettype none

module m68k_ea_calc import m68k_ea_pkg::*; (
	input  item_t   item,
	output result_t res0,
	output result_t res1,
	output logic    two_words
);

	logic [31:0] val;
	logic [31:0] loc2;
	logic [31:0] loc4;
	logic [31:0] pc_disp;
	logic [31:0] d8_src;
	logic        fits_s16;
	logic        fits_pc16;
	logic        fits_d8;
	logic        fits_imm8;
	logic        fits_imm16;
	logic [5:0]  ea;
	addr_mode_t  mode;

	assign val  = item.operand_value;
	assign mode = addr_mode_t'(item.addr_mode);

	// Location arithmetic and the PC-relative displacement.
	assign loc2    = item.location + 32'd2;
	assign loc4    = item.location + 32'd4;
	assign pc_disp = val - loc2;
	assign d8_src  = (mode == MODE_PC_IDX) ? pc_disp : val;

	// Range checks on the 32-bit values, done on the upper bits; immediates also accept unsigned values.
	assign fits_s16   = (&val[31:15]) | ~(|val[31:15]);
	assign fits_pc16  = (&pc_disp[31:15]) | ~(|pc_disp[31:15]);
	assign fits_d8    = (&d8_src[31:7]) | ~(|d8_src[31:7]);
	assign fits_imm8  = (&val[31:7]) | ~(|val[31:8]);
	assign fits_imm16 = (&val[31:15]) | ~(|val[31:16]);

	// EA field: mode and register for modes 0-6, fixed codes for mode 7.
	always_comb begin
		unique case (mode)
			MODE_ABS_W:   ea = EA_ABS_W;
			MODE_ABS_L:   ea = EA_ABS_L;
			MODE_PC_DISP: ea = EA_PC_DISP;
			MODE_PC_IDX:  ea = EA_PC_IDX;
			MODE_IMM:     ea = EA_IMM;
			default:      ea = {item.addr_mode[2:0], item.base_reg};
		endcase
	end

	// Result words per mode.
	always_comb begin
		res0               = '0;
		res0.ea_field      = ea;
		res0.ea_valid      = 1'b1;
		res0.last_result   = 1'b1;
		res0.error_code    = ERR_OK;
		res0.next_location = item.location;
		res1               = res0;
		res1.ext_word      = val[15:0];
		res1.word_valid    = 1'b1;
		res1.next_location = loc4;
		two_words          = 1'b0;
		unique case (mode)
			MODE_DN, MODE_AN, MODE_AN_IND, MODE_AN_POST, MODE_AN_PRE: begin
			end
			MODE_AN_DISP, MODE_ABS_W: begin
				res0.ext_word      = val[15:0];
				res0.word_valid    = 1'b1;
				res0.next_location = loc2;
				if (!fits_s16) begin
					res0.error_code = (mode == MODE_ABS_W) ? ERR_ABS_W : ERR_D16;
				end
			end
			MODE_AN_IDX, MODE_PC_IDX: begin
				res0.ext_word      = {item.index_reg_num, item.index_is_long,
					3'b000, d8_src[7:0]};
				res0.word_valid    = 1'b1;
				res0.next_location = loc2;
				if (!fits_d8) begin
					res0.error_code = ERR_D8;
				end
			end
			MODE_PC_DISP: begin
				res0.ext_word      = pc_disp[15:0];
				res0.word_valid    = 1'b1;
				res0.next_location = loc2;
				if (!fits_pc16) begin
					res0.error_code = ERR_PC_D16;
				end
			end
			MODE_ABS_L: begin
				res0.ext_word      = val[31:16];
				res0.word_valid    = 1'b1;
				res0.last_result   = 1'b0;
				res0.next_location = loc2;
				two_words          = 1'b1;
			end
			MODE_IMM: begin
				res0.word_valid    = 1'b1;
				res0.next_location = loc2;
				if (item.operand_size == SIZE_BYTE) begin
					res0.ext_word = {8'h00, val[7:0]};
					if (!fits_imm8) begin
						res0.error_code = ERR_IMM8;
					end
				end else if (item.operand_size == SIZE_LONG) begin
					res0.ext_word    = val[31:16];
					res0.last_result = 1'b0;
					two_words        = 1'b1;
				end else begin
					res0.ext_word = val[15:0];
					if (!fits_imm16) begin
						res0.error_code = ERR_IMM16;
					end
				end
			end
			default: begin
				// Modes with no encoding.
				res0.ea_field   = 6'd0;
				res0.ea_valid   = 1'b0;
				res0.error_code = ERR_BAD_MODE;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/m68k_ea_emit.sv]
// ----------------------------------------------------------------------------
// m68k_ea_emit
// Result register with a second-word holding register. Sends the first
// result of an operand and, for long values, the second on the next slot.
// ----------------------------------------------------------------------------
`default_nettype none

module m68k_ea_emit import m68k_ea_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  result_t      in_res0,
	input  result_t      in_res1,
	input  logic         in_two,
	output logic         in_take,
	input  logic         out_ready,
	output logic         out_valid,
	output result_t      out_res,
	output emit_status_t status
);

	logic    out_valid_q;
	logic    pend_q;
	result_t out_q;
	result_t pend_res_q;
	logic    out_free;

	// The result register can load when empty or when its item is taken.
	assign out_free = !out_valid_q || out_ready;
	assign in_take  = out_free && !pend_q && in_valid;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
				pend_q      <= in_valid && in_two;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_q <= pend_res_q;
			end else if (in_valid) begin
				out_q      <= in_res0;
				pend_res_q <= in_res1;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_res           = out_q;
	assign status.out_valid  = out_valid_q;
	assign status.pend_valid = pend_q;

endmodule

`default_nettype wire

[sv/m68k_operand_ext_word_encoder_top.sv]
// An operand's first result passes the input register and then the result register before it is presented.
// Throughput: one operand per cycle when it yields one result and m_tready is high;
// long immediates and abs.L hold the next operand back while their second word is held.
// Reset: arst_n clears the input and result valid flags and the second-word flag.
// Input is accepted while the result register waits on m_tready if the input register is empty.
// ----------------------------------------------------------------------------
// m68k_operand_ext_word_encoder_top
// 68000 operand encoder: EA field and up to two extension words per operand,
// with range checks and location tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module m68k_operand_ext_word_encoder_top import m68k_ea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] base_reg, [34:3] operand_value, [38:35] index_reg_num,
	// [39] index_is_long, [41:40] operand_size, [73:42] location, rest zero
	input  logic [79:0] s_tdata,
	// [3:0] addr_mode
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] ea_field, [21:6] ext_word, [24:22] error_code,
	// [56:25] next_location, rest zero
	output logic [63:0] m_tdata,
	// [0] ea_valid, [1] word_valid
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	item_t        item_s1;
	logic         valid_s1;
	logic         take;
	result_t      res0;
	result_t      res1;
	logic         two_words;
	result_t      out_res;
	emit_status_t status;

	assign s_tready = !valid_s1 || take;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.addr_mode     <= s_tuser;
			item_s1.base_reg      <= s_tdata[2:0];
			item_s1.operand_value <= s_tdata[34:3];
			item_s1.index_reg_num <= s_tdata[38:35];
			item_s1.index_is_long <= s_tdata[39];
			item_s1.operand_size  <= s_tdata[41:40];
			item_s1.location      <= s_tdata[73:42];
		end
	end

	// Encoding logic.
	m68k_ea_calc u_calc (
		.item      (item_s1),
		.res0      (res0),
		.res1      (res1),
		.two_words (two_words)
	);

	// Result stage.
	m68k_ea_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_res0   (res0),
		.in_res1   (res1),
		.in_two    (two_words),
		.in_take   (take),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.status    (status)
	);

	// Output packing.
	assign m_tdata = {7'd0, out_res.next_location, out_res.error_code,
		out_res.ext_word, out_res.ea_field};
	assign m_tuser = {out_res.word_valid, out_res.ea_valid};
	assign m_tlast = out_res.last_result;

	`include "m68k_operand_ext_word_encoder_top_assert.svh"

	// A held second word always sits behind a valid first word.
	`M68K_EA_ASSERT_NOW(a_pend_behind_out, status.pend_valid, status.out_valid, "second word without first")
	// A result that is not last is always followed by its second word.
	`M68K_EA_ASSERT_NOW(a_notlast_has_pend, m_tvalid && !m_tlast, status.pend_valid, "non-last result with no second word")
	// Errors are reported only on the last result.
	`M68K_EA_ASSERT_NOW(a_err_on_last, m_tvalid && (m_tdata[24:22] != ERR_OK), m_tlast, "error on non-last result")
	// The next operand waits while a second word is held.
	`M68K_EA_ASSERT_NEXT(a_s1_holds, status.pend_valid && valid_s1, valid_s1, "operand lost while second word held")

endmodule

`default_nettype wire
